// ===== hw/rtl/lrs_pkg.sv =====
package lrs_pkg;

   localparam int LRS_WAYS      = 16;
   localparam int LRS_TAG_BITS  = 48;
   localparam logic [1:0] EPOCH_MAX = 2'd3;

   typedef enum logic [2:0] {
      OP_FIND   = 3'd0,
      OP_FILL   = 3'd1,
      OP_ACCESS = 3'd2,
      OP_SET    = 3'd3,
      OP_GET    = 3'd4,
      OP_VICTIM = 3'd5
   } opcode_type;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_READ = 4'b0010,
      ST_EXEC = 4'b0100,
      ST_SCAN = 4'b1000
   } state_type;

   typedef struct packed {
      logic [2:0]  opcode;
      logic [3:0]  way;
      logic [47:0] tag;
      logic [2:0]  block_state;
      logic [7:0]  stream;
      logic [7:0]  trace_stream;
      logic        demand_fill;
      logic        spill;
      logic [15:0] busy_mask;
   } req_type;

   typedef struct packed {
      logic        found;
      logic [3:0]  way_out;
      logic [47:0] tag_out;
      logic [2:0]  state_out;
      logic [7:0]  stream_out;
      logic        dirty_out;
      logic [1:0]  epoch_out;
   } rsp_type;

   typedef struct packed {
      logic move_front;
      logic drop;
      logic take_free;
      logic give_free;
   } ord_cmd_type;

endpackage

// ===== hw/rtl/lrs_ram.sv =====
module lrs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== hw/rtl/lrs_order.sv =====
module lrs_order
   import lrs_pkg::*;
#(
   parameter int WAYS = LRS_WAYS
) (
   input  logic                        clock,
   input  logic                        reset,
   input  ord_cmd_type                 cmd,
   input  logic [$clog2(WAYS)-1:0]     way,
   input  logic [$clog2(WAYS)-1:0]     rd_idx,
   output logic [$clog2(WAYS)-1:0]     rd_way,
   output logic [$clog2(WAYS)-1:0]     free_head,
   output logic                        free_has,
   output logic [$clog2(WAYS+1)-1:0]   vcount,
   output logic [$clog2(WAYS+1)-1:0]   fcount
);

   localparam int WB = $clog2(WAYS);
   localparam int CW = $clog2(WAYS + 1);

   logic [WB-1:0] rec_ff  [WAYS];
   logic [WB-1:0] rec_in  [WAYS];
   logic [WB-1:0] free_ff [WAYS];
   logic [WB-1:0] free_in [WAYS];
   logic [CW-1:0] vcount_ff, vcount_in;
   logic [CW-1:0] fcount_ff, fcount_in;

   logic [WAYS-1:0] rmatch, rlt, rle;
   logic [WAYS-1:0] fmatch, flt, fle;
   logic            rec_has;

   always_comb begin
      for (int i = 0; i < WAYS; i++) begin
         rmatch[i] = (CW'(i) < vcount_ff) && (rec_ff[i] == way);
         fmatch[i] = (CW'(i) < fcount_ff) && (free_ff[i] == way);
      end
      rlt[0] = 1'b0;
      flt[0] = 1'b0;
      for (int i = 1; i < WAYS; i++) begin
         rlt[i] = rlt[i-1] | rmatch[i-1];
         flt[i] = flt[i-1] | fmatch[i-1];
      end
      rle = rlt | rmatch;
      fle = flt | fmatch;
   end

   assign rec_has  = rle[WAYS-1];
   assign free_has = fle[WAYS-1];

   always_comb begin
      rec_in    = rec_ff;
      free_in   = free_ff;
      vcount_in = vcount_ff;
      fcount_in = fcount_ff;
      if (cmd.move_front && (rec_has || vcount_ff < CW'(WAYS))) begin
         rec_in[0] = way;
         for (int i = 1; i < WAYS; i++) begin
            if (!rlt[i]) begin
               rec_in[i] = rec_ff[i-1];
            end
         end
         if (!rec_has) begin
            vcount_in = vcount_ff + 1'b1;
         end
      end else if (cmd.drop && rec_has) begin
         for (int i = 0; i < WAYS - 1; i++) begin
            if (rle[i]) begin
               rec_in[i] = rec_ff[i+1];
            end
         end
         vcount_in = vcount_ff - 1'b1;
      end
      if (cmd.take_free && free_has) begin
         for (int i = 0; i < WAYS - 1; i++) begin
            if (fle[i]) begin
               free_in[i] = free_ff[i+1];
            end
         end
         fcount_in = fcount_ff - 1'b1;
      end else if (cmd.give_free && fcount_ff < CW'(WAYS)) begin
         free_in[fcount_ff[WB-1:0]] = way;
         fcount_in = fcount_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WAYS; i++) begin
            rec_ff[i]  <= '0;
            free_ff[i] <= WB'(i);
         end
         vcount_ff <= '0;
         fcount_ff <= CW'(WAYS);
      end else begin
         rec_ff    <= rec_in;
         free_ff   <= free_in;
         vcount_ff <= vcount_in;
         fcount_ff <= fcount_in;
      end
   end

   assign rd_way    = rec_ff[rd_idx];
   assign free_head = free_ff[0];
   assign vcount    = vcount_ff;
   assign fcount    = fcount_ff;

`ifndef SYNTHESIS
   a_count_sum: assert property (@(posedge clock) disable iff (reset)
      (32'(vcount_ff) + 32'(fcount_ff)) == WAYS)
      else $error("list counts out of balance");
`endif

endmodule

// ===== hw/rtl/lru_set_replacement.sv =====
// LRU replacement keeper for one cache set.
// Input: present an item on req_item with start high; it is taken at the
// rising edge where start is high and busy is low. busy stays high while
// the item is worked on, so one item is in flight at a time.
// Output: each item yields one transaction on rsp_item, marked by a one-cycle
// rsp_strobe. The receiver cannot stall; the transaction must be taken.
// After acceptance, fill, access, set_state, get and unused opcodes read
// their entry in ST_READ, then act on it in ST_EXEC, where fill, access
// and set_state write it back on success. find walks the recency order
// through the entry RAM, reading and checking one entry at a time, until
// a hit, or answers a miss once every valid entry is checked. victim gives
// the first free way if any, else skips busy ways from the least recent end.
// busy falls in the cycle rsp_strobe rises, so a new item may be accepted
// there. Entry fields sit in one RAM with registered read; a flag per way
// marks entries written since reset, others read as invalid, clean, epoch 0.
// Reset: synchronous; all ways free in order 0 upward, recency order empty.
module lru_set_replacement
   import lrs_pkg::*;
#(
   parameter int WAYS     = LRS_WAYS,
   parameter int TAG_BITS = LRS_TAG_BITS
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   output logic    rsp_strobe,
   output rsp_type rsp_item
);

   localparam int WB = $clog2(WAYS);
   localparam int CW = $clog2(WAYS + 1);
   localparam int EW = TAG_BITS + 14;

   state_type     state_ff, state_in;
   req_type       req_ff, req_in;
   logic [CW-1:0] cnt_ff, cnt_in, cnt_dec;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff, rsp_in;
   logic [WAYS-1:0] wvalid_ff;
   logic          ent_valid_ff;

   ord_cmd_type   cmd;
   logic [WB-1:0] rd_idx, rd_way, free_head, wi;
   logic          free_has;
   logic [CW-1:0] vcount, fcount;

   logic          ram_we;
   logic [WB-1:0] ram_raddr;
   logic [EW-1:0] ram_wdata, ram_rdata;

   logic [63:0]         tag64, st_tag64;
   logic [TAG_BITS-1:0] req_tag, st_tag;
   logic [7:0]          st_stream;
   logic [2:0]          st_state;
   logic                st_dirty;
   logic [1:0]          st_epoch, new_epoch;
   logic [7:0]          w8, rw8;
   logic                inrange, is_find, vbusy;

   assign tag64   = 64'(req_ff.tag);
   assign req_tag = tag64[TAG_BITS-1:0];
   assign w8      = 8'(req_ff.way);
   assign wi      = w8[WB-1:0];
   assign inrange = 32'(req_ff.way) < WAYS;
   assign is_find = req_ff.opcode == OP_FIND;
   assign cnt_dec = cnt_ff - 1'b1;
   assign rd_idx  = is_find ? cnt_ff[WB-1:0] : cnt_dec[WB-1:0];
   assign rw8     = 8'(rd_way);
   assign vbusy   = (rw8 < 8'd16) && req_ff.busy_mask[rw8[3:0]];
   assign ram_raddr = is_find ? rd_way : wi;

   assign st_tag    = ram_rdata[EW-1 -: TAG_BITS];
   assign st_stream = ram_rdata[13:6];
   assign st_state  = ent_valid_ff ? ram_rdata[5:3] : 3'd0;
   assign st_dirty  = ent_valid_ff ? ram_rdata[2]   : 1'b0;
   assign st_epoch  = ent_valid_ff ? ram_rdata[1:0] : 2'd0;
   assign st_tag64  = 64'(st_tag);

   always_comb begin
      new_epoch = st_epoch;
      if (req_ff.demand_fill) begin
         if (st_stream == req_ff.trace_stream) begin
            new_epoch = (st_epoch == EPOCH_MAX) ? EPOCH_MAX : st_epoch + 2'd1;
         end else begin
            new_epoch = 2'd0;
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = '0;
      ram_we       = 1'b0;
      ram_wdata    = {st_tag, req_ff.stream, st_state, st_dirty, st_epoch};
      cmd          = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in = req_item;
               if (req_item.opcode == OP_VICTIM) begin
                  cnt_in   = vcount;
                  state_in = ST_SCAN;
               end else begin
                  cnt_in   = '0;
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            if (is_find && cnt_ff >= vcount) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_IDLE;
            case (req_ff.opcode)
               OP_FIND: begin
                  if (st_tag == req_tag) begin
                     rsp_valid_in   = 1'b1;
                     rsp_in.found   = 1'b1;
                     rsp_in.way_out = rw8[3:0];
                  end else begin
                     cnt_in   = cnt_ff + 1'b1;
                     state_in = ST_READ;
                  end
               end
               OP_FILL: begin
                  rsp_valid_in = 1'b1;
                  if (inrange && st_state == 3'd0 && req_ff.block_state != 3'd0
                      && free_has) begin
                     rsp_in.found   = 1'b1;
                     ram_we         = 1'b1;
                     ram_wdata      = {req_tag, req_ff.stream, req_ff.block_state,
                                       req_ff.spill, 2'd0};
                     cmd.take_free  = 1'b1;
                     cmd.move_front = 1'b1;
                  end
               end
               OP_ACCESS: begin
                  rsp_valid_in = 1'b1;
                  if (inrange && st_state != 3'd0) begin
                     rsp_in.found   = 1'b1;
                     ram_we         = 1'b1;
                     ram_wdata      = {st_tag, req_ff.stream, st_state,
                                       req_ff.spill, new_epoch};
                     cmd.move_front = 1'b1;
                  end
               end
               OP_SET: begin
                  rsp_valid_in = 1'b1;
                  if (inrange && st_state != 3'd0 && st_tag == req_tag) begin
                     rsp_in.found = 1'b1;
                     ram_we       = 1'b1;
                     if (req_ff.block_state != 3'd0) begin
                        ram_wdata = {st_tag, req_ff.stream, req_ff.block_state,
                                     st_dirty, st_epoch};
                     end else begin
                        ram_wdata     = {st_tag, req_ff.stream, 3'd0, st_dirty, 2'd0};
                        cmd.drop      = 1'b1;
                        cmd.give_free = 1'b1;
                     end
                  end
               end
               OP_GET: begin
                  rsp_valid_in = 1'b1;
                  if (inrange) begin
                     rsp_in.found      = 1'b1;
                     rsp_in.tag_out    = st_tag64[47:0];
                     rsp_in.state_out  = st_state;
                     rsp_in.stream_out = st_stream;
                     rsp_in.dirty_out  = st_dirty;
                     rsp_in.epoch_out  = st_epoch;
                  end
               end
               default: begin
                  rsp_valid_in = 1'b1;
               end
            endcase
         end
         ST_SCAN: begin
            if (fcount != '0) begin
               rsp_valid_in   = 1'b1;
               rsp_in.found   = 1'b1;
               rsp_in.way_out = 4'(free_head);
               state_in       = ST_IDLE;
            end else if (cnt_ff == '0) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else if (!vbusy) begin
               rsp_valid_in   = 1'b1;
               rsp_in.found   = 1'b1;
               rsp_in.way_out = rw8[3:0];
               state_in       = ST_IDLE;
            end else begin
               cnt_in = cnt_dec;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         wvalid_ff    <= '0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
         if (ram_we) begin
            wvalid_ff[wi] <= 1'b1;
         end
      end
      req_ff       <= req_in;
      rsp_ff       <= rsp_in;
      ent_valid_ff <= wvalid_ff[ram_raddr];
   end

   lrs_ram #(
      .WIDTH (EW),
      .DEPTH (WAYS)
   ) u_entry_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (wi),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   lrs_order #(
      .WAYS (WAYS)
   ) u_order (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .way       (wi),
      .rd_idx    (rd_idx),
      .rd_way    (rd_way),
      .free_head (free_head),
      .free_has  (free_has),
      .vcount    (vcount),
      .fcount    (fcount)
   );

   assign busy       = state_ff != ST_IDLE;
   assign rsp_strobe = rsp_valid_ff;
   assign rsp_item   = rsp_ff;

`ifndef SYNTHESIS
   a_rsp_spaced: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("two transactions in consecutive cycles");
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted transaction did not raise busy");
   a_miss_way: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_item.found) |-> (rsp_item.way_out == 4'd0))
      else $error("way reported on a miss");
   a_write_exec: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == ST_EXEC && rsp_valid_in))
      else $error("entry written outside a completing step");
`endif

endmodule

// ===== sim/lru_set_replacement_tb.sv =====
module lru_set_replacement_tb;
   import lrs_pkg::*;

   localparam int NWAYS = LRS_WAYS;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_item = '0;
   logic    rsp_strobe;
   rsp_type rsp_item;

   logic [47:0] way_tag [NWAYS];
   logic [2:0]  way_state [NWAYS];
   logic [7:0]  way_stream [NWAYS];
   logic        way_dirty [NWAYS];
   logic [1:0]  way_epoch [NWAYS];
   logic [3:0]  recency_q [$];
   logic [3:0]  free_q [$];
   logic        written [NWAYS];

   rsp_type expected_rsp_q [$];
   int      error_count = 0;
   int      burst_left = 0;

   lru_set_replacement i_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #50_000_000;
      $display("lru_set_replacement_tb: FAIL");
      $finish;
   end

   function automatic void drop_recency(input logic [3:0] w);
      for (int i = 0; i < recency_q.size(); i++)
         if (recency_q[i] == w) begin
            recency_q.delete(i);
            break;
         end
   endfunction

   function automatic rsp_type predict_set(input req_type r);
      rsp_type o;
      int      w;
      int      idx;
      o = '0;
      w = int'(r.way);
      case (r.opcode)
         OP_FIND: begin
            foreach (recency_q[i])
               if (way_tag[recency_q[i]] == r.tag) begin
                  o.found = 1'b1;
                  o.way_out = recency_q[i];
                  break;
               end
         end
         OP_FILL: begin
            idx = -1;
            foreach (free_q[i]) if (free_q[i] == r.way) idx = i;
            if (way_state[w] == 3'd0 && r.block_state != 3'd0 && idx >= 0) begin
               free_q.delete(idx);
               way_tag[w] = r.tag;
               way_state[w] = r.block_state;
               way_stream[w] = r.stream;
               way_dirty[w] = r.spill;
               way_epoch[w] = 2'd0;
               written[w] = 1'b1;
               recency_q.push_front(r.way);
               o.found = 1'b1;
            end
         end
         OP_ACCESS: begin
            if (way_state[w] != 3'd0) begin
               if (r.demand_fill) begin
                  if (way_stream[w] == r.trace_stream)
                     way_epoch[w] = (way_epoch[w] == EPOCH_MAX) ? EPOCH_MAX
                                                               : way_epoch[w] + 2'd1;
                  else
                     way_epoch[w] = 2'd0;
               end
               way_stream[w] = r.stream;
               way_dirty[w] = r.spill;
               drop_recency(r.way);
               recency_q.push_front(r.way);
               o.found = 1'b1;
            end
         end
         OP_SET: begin
            if (way_state[w] != 3'd0 && way_tag[w] == r.tag) begin
               way_stream[w] = r.stream;
               if (r.block_state != 3'd0) begin
                  way_state[w] = r.block_state;
               end else begin
                  way_state[w] = 3'd0;
                  way_epoch[w] = 2'd0;
                  drop_recency(r.way);
                  if (free_q.size() < NWAYS) free_q.push_back(r.way);
               end
               o.found = 1'b1;
            end
         end
         OP_GET: begin
            o.found = 1'b1;
            o.tag_out = way_tag[w];
            o.state_out = way_state[w];
            o.stream_out = way_stream[w];
            o.dirty_out = way_dirty[w];
            o.epoch_out = way_epoch[w];
         end
         OP_VICTIM: begin
            if (free_q.size() > 0) begin
               o.found = 1'b1;
               o.way_out = free_q[0];
            end else begin
               for (int i = recency_q.size() - 1; i >= 0; i--)
                  if (!r.busy_mask[recency_q[i]]) begin
                     o.found = 1'b1;
                     o.way_out = recency_q[i];
                     break;
                  end
            end
         end
         default: ;
      endcase
      return o;
   endfunction

   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_strobe) begin
         if (expected_rsp_q.size() == 0) begin
            $display("%0t: unexpected transaction %h", $time, rsp_item);
            error_count++;
         end else begin
            e = expected_rsp_q.pop_front();
            if (rsp_item.found !== e.found || rsp_item.way_out !== e.way_out
                || rsp_item.tag_out !== e.tag_out || rsp_item.state_out !== e.state_out
                || rsp_item.stream_out !== e.stream_out
                || rsp_item.dirty_out !== e.dirty_out
                || rsp_item.epoch_out !== e.epoch_out) begin
               $display("%0t: mismatch expected %h actual %h", $time, e, rsp_item);
               error_count++;
            end
         end
      end
   end

   task automatic send_item(input req_type r);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 20);
         if ($urandom_range(0, 2) != 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
      end
      burst_left--;
      start <= 1'b1;
      req_item <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      expected_rsp_q.push_back(predict_set(r));
   endtask

   function automatic req_type rand_req();
      req_type r;
      r.opcode = opcode_type'(3'($urandom_range(0, 5)));
      r.way = 4'($urandom_range(0, NWAYS - 1));
      r.tag = 48'({$urandom, $urandom});
      if ($urandom_range(0, 3) != 0) r.tag = 48'($urandom_range(0, 7));
      r.block_state = 3'($urandom_range(0, 7));
      r.stream = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                             : 8'($urandom_range(0, 3));
      r.trace_stream = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                   : 8'($urandom_range(0, 3));
      r.demand_fill = 1'($urandom_range(0, 1));
      r.spill = 1'($urandom_range(0, 1));
      r.busy_mask = ($urandom_range(0, 1) != 0) ? 16'($urandom_range(0, 65535))
                        : (16'hFFFF & ~(16'h1 << 4'($urandom_range(0, 15))));
      return r;
   endfunction

   function automatic req_type fix_get(input req_type r);
      int pick;
      if (r.opcode == OP_GET && !written[r.way]) begin
         pick = -1;
         for (int i = 0; i < NWAYS; i++) if (written[i]) pick = i;
         if (pick < 0) r.opcode = OP_VICTIM;
         else r.way = 4'(pick);
      end
      if (r.opcode == OP_SET && $urandom_range(0, 3) != 0) r.tag = way_tag[r.way];
      return r;
   endfunction

   task automatic test_directed();
      req_type r;
      r = '0;
      r.opcode = OP_VICTIM; send_item(r);
      r.opcode = OP_FIND; send_item(r);
      r.opcode = OP_ACCESS; send_item(r);
      r.opcode = OP_FILL; r.block_state = 3'd0; send_item(r);
      for (int w = 0; w < NWAYS; w++) begin
         r = '0;
         r.opcode = OP_FILL; r.way = 4'(w); r.block_state = 3'd7; r.spill = w[0];
         r.tag = (w == 15) ? 48'hFFFF_FFFF_FFFF : 48'(w);
         r.stream = (w == 15) ? 8'hFF : 8'd0;
         send_item(r);
      end
      r = '0; r.opcode = OP_FILL; r.way = 4'd3; r.block_state = 3'd1; send_item(r);
      r = '0; r.opcode = OP_VICTIM; r.busy_mask = 16'hFFFF; send_item(r);
      r.busy_mask = 16'h7FFE; send_item(r);
      r = '0; r.opcode = OP_ACCESS; r.way = 4'd15; r.demand_fill = 1'b1;
      r.trace_stream = 8'hFF; r.stream = 8'hFF; r.spill = 1'b1;
      repeat (4) send_item(r);
      r.trace_stream = 8'd1; send_item(r);
      r = '0; r.opcode = OP_GET; r.way = 4'd15; send_item(r);
      r = '0; r.opcode = OP_FIND; r.tag = 48'hFFFF_FFFF_FFFF; send_item(r);
      r = '0; r.opcode = OP_SET; r.way = 4'd15; r.tag = 48'd1; send_item(r);
      r.tag = 48'hFFFF_FFFF_FFFF; r.block_state = 3'd0; send_item(r);
      r = '0; r.opcode = OP_VICTIM; send_item(r);
      r = '0; r.opcode = opcode_type'(3'd6); send_item(r);
      r = '0; r.opcode = opcode_type'(3'd7); r.way = 4'd15; send_item(r);
   endtask

   task automatic test_random();
      for (int n = 0; n < 1420; n++)
         send_item(fix_get(rand_req()));
   endtask

   initial begin
      int guard;
      for (int i = 0; i < NWAYS; i++) begin
         way_tag[i] = '0; way_state[i] = '0; way_stream[i] = '0;
         way_dirty[i] = 1'b0; way_epoch[i] = '0; written[i] = 1'b0;
         free_q.push_back(4'(i));
      end
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random();
      start <= 1'b0;
      guard = 0;
      while (expected_rsp_q.size() != 0 && guard < 1000) begin
         @(posedge clock);
         guard++;
      end
      repeat (50) @(posedge clock);
      if (error_count == 0 && expected_rsp_q.size() == 0)
         $display("lru_set_replacement_tb: PASS");
      else
         $display("lru_set_replacement_tb: FAIL");
      $finish;
   end

endmodule
